/* hw/rtl/arstf_pkg.sv */
// ----------------------------------------------------------------------------
// arstf_pkg
// Shared types, codes, sizes and the sine table for the affine texel fetch.
// ----------------------------------------------------------------------------
package arstf_pkg;

    localparam int SCREEN_WIDTH_DEF  = 256;
    localparam int SCREEN_HEIGHT_DEF = 240;

    localparam int MAP_AW     = 16;
    localparam int TEXEL_W    = 16;
    localparam int COORD_W    = 8;
    localparam int POS_W      = 16;
    localparam int TRIG_W     = 10;
    localparam int ZOOM_W     = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_START  = 2'd1;
    localparam logic [1:0] REQ_RENDER = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZOOM     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd3;

    // trunc(256 * sin(j * pi / 128)), j = 0..64
    localparam logic [8:0] QUARTER_SINE [65] = '{
        9'd0,   9'd6,   9'd12,  9'd18,  9'd25,  9'd31,  9'd37,  9'd43,
        9'd49,  9'd56,  9'd62,  9'd68,  9'd74,  9'd80,  9'd86,  9'd92,
        9'd97,  9'd103, 9'd109, 9'd115, 9'd120, 9'd126, 9'd131, 9'd136,
        9'd142, 9'd147, 9'd152, 9'd157, 9'd162, 9'd167, 9'd171, 9'd176,
        9'd181, 9'd185, 9'd189, 9'd193, 9'd197, 9'd201, 9'd205, 9'd209,
        9'd212, 9'd216, 9'd219, 9'd222, 9'd225, 9'd228, 9'd231, 9'd234,
        9'd236, 9'd238, 9'd241, 9'd243, 9'd244, 9'd246, 9'd248, 9'd249,
        9'd251, 9'd252, 9'd253, 9'd254, 9'd254, 9'd255, 9'd255, 9'd255,
        9'd256
    };

    function automatic logic signed [TRIG_W-1:0] sine_of(input logic [7:0] idx);
        logic [5:0]        r;
        logic [1:0]        q;
        logic [6:0]        k;
        logic [TRIG_W-1:0] v;
        r = idx[5:0];
        q = idx[7:6];
        k = q[0] ? 7'(7'd64 - {1'b0, r}) : {1'b0, r};
        v = {1'b0, QUARTER_SINE[k]};
        sine_of = q[1] ? TRIG_W'(-v) : v;
    endfunction

    typedef struct packed {
        logic             done;
        logic [POS_W-1:0] step_x;
        logic [POS_W-1:0] step_y;
        logic [POS_W-1:0] org_x;
        logic [POS_W-1:0] org_y;
    } t_setup;

endpackage

/* hw/rtl/affine_rotate_scale_texel_fetch.sv */
// ----------------------------------------------------------------------------
// affine_rotate_scale_texel_fetch
// Rotated and zoomed view of a 256x256 texel map, one texel per render beat.
//
//   channel   dir  handshake                      payload
//   s_axis    in   s_axis_tvalid / s_axis_tready   tuser req_type, tdata index, texel
//   m_axis    out  m_axis_tvalid / m_axis_tready   tdata pixel, x, y; tlast frame end
//   cfg       in   i_cfg_we (no wait)              i_cfg_idx, i_cfg_data
//
// A render result passes through the registered read of the map memory and
// then the output register, which it enters only when that register is free.
// A start beat blocks input while the setup sequencer runs and loads the frame.
// Otherwise input stalls only when a fetched texel waits on a full, stalled output register.
// Reset is synchronous; no frame is active after it, and the map memory is not cleared.
// ----------------------------------------------------------------------------
module affine_rotate_scale_texel_fetch #(
    parameter int SCREEN_WIDTH  = arstf_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = arstf_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [arstf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [arstf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [31:0]                      s_axis_tdata,  // map_index, texel
    input  logic [1:0]                       s_axis_tuser,  // req_type
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [31:0]                      m_axis_tdata,  // pixel, screen_x, screen_y
    output logic                             m_axis_tlast
);

    localparam int PW = arstf_pkg::POS_W;
    localparam int CW = arstf_pkg::COORD_W;
    localparam int TX = arstf_pkg::TEXEL_W;
    localparam logic [CW-1:0] LAST_X = CW'(SCREEN_WIDTH - 1);
    localparam logic [CW-1:0] LAST_Y = CW'(SCREEN_HEIGHT - 1);

    arstf_pkg::t_setup     w_setup;
    logic                  w_busy;
    logic [TX-1:0]         w_rdata;
    logic                  w_accept;
    logic                  w_load;
    logic                  w_start;
    logic                  w_render;
    logic                  w_move;
    logic                  w_last_col;
    logic                  w_last_row;

    logic [2*PW-1:0]       r_acc;
    logic [PW-1:0]         r_row_x;
    logic [PW-1:0]         r_row_y;
    logic [PW-1:0]         r_step_x;
    logic [PW-1:0]         r_step_y;
    logic [CW-1:0]         r_col;
    logic [CW-1:0]         r_row;
    logic                  r_active;
    logic                  r_pend;
    logic [CW-1:0]         r_pend_x;
    logic [CW-1:0]         r_pend_y;
    logic                  r_pend_last;
    logic                  r_out_valid;
    logic [TX-1:0]         r_out_pixel;
    logic [CW-1:0]         r_out_x;
    logic [CW-1:0]         r_out_y;
    logic                  r_out_last;
    logic [PW-1:0]         n_row_x;
    logic [PW-1:0]         n_row_y;

    assign w_move        = r_pend && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !w_busy && (!r_pend || !r_out_valid || m_axis_tready);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_load        = w_accept && (s_axis_tuser == arstf_pkg::REQ_LOAD);
    assign w_start       = w_accept && (s_axis_tuser == arstf_pkg::REQ_START);
    assign w_render      = w_accept && (s_axis_tuser == arstf_pkg::REQ_RENDER) && r_active;
    assign w_last_col    = (r_col == LAST_X);
    assign w_last_row    = (r_row == LAST_Y);
    assign n_row_x       = PW'(r_row_x - r_step_y);
    assign n_row_y       = PW'(r_row_y + r_step_x);

    arstf_setup #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_setup (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_start    (w_start),
        .o_busy     (w_busy),
        .o_res      (w_setup)
    );

    arstf_map_ram u_map (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (s_axis_tdata[15:0]),
        .i_wdata (s_axis_tdata[31:16]),
        .i_re    (w_render),
        .i_raddr ({r_acc[31:24], r_acc[15:8]}),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_row_x  <= '0;
            r_row_y  <= '0;
            r_step_x <= '0;
            r_step_y <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_active <= 1'b0;
        end else if (w_setup.done) begin
            r_step_x <= w_setup.step_x;
            r_step_y <= w_setup.step_y;
            r_row_x  <= w_setup.org_x;
            r_row_y  <= w_setup.org_y;
            r_acc    <= {w_setup.org_y, w_setup.org_x};
            r_col    <= '0;
            r_row    <= '0;
            r_active <= 1'b1;
        end else if (w_render) begin
            if (!w_last_col) begin
                r_acc <= (2*PW)'(r_acc + {r_step_y, r_step_x});
                r_col <= CW'(r_col + 1'b1);
            end else begin
                r_row_x <= n_row_x;
                r_row_y <= n_row_y;
                r_acc   <= {n_row_y, n_row_x};
                r_col   <= '0;
                if (w_last_row) begin
                    r_active <= 1'b0;
                end else begin
                    r_row <= CW'(r_row + 1'b1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_render) begin
                r_pend <= 1'b1;
            end else if (w_move) begin
                r_pend <= 1'b0;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_render) begin
            r_pend_x    <= r_col;
            r_pend_y    <= r_row;
            r_pend_last <= w_last_col && w_last_row;
        end
        if (w_move) begin
            r_out_pixel <= w_rdata;
            r_out_x     <= r_pend_x;
            r_out_y     <= r_pend_y;
            r_out_last  <= r_pend_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_y, r_out_x, r_out_pixel};
    assign m_axis_tlast  = r_out_last;

    a_no_read_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && r_out_valid && !m_axis_tready) |-> !w_render)
        else $error("map read issued while fetched texel is held");

    a_no_beat_on_setup_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_setup.done |-> !s_axis_tready)
        else $error("input beat taken while frame setup loads");

    a_last_at_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |->
        (m_axis_tdata[23:16] == LAST_X) && (m_axis_tdata[31:24] == LAST_Y))
        else $error("frame end flagged away from the last pixel");

    a_frame_after_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_setup.done |=> (r_active && (r_col == '0) && (r_row == '0)))
        else $error("frame not restarted at top-left corner");

endmodule

/* hw/rtl/arstf_map_ram.sv */
// ----------------------------------------------------------------------------
// arstf_map_ram
// Texel map: one write port, one registered read port.
// ----------------------------------------------------------------------------
module arstf_map_ram (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [arstf_pkg::MAP_AW-1:0]  i_waddr,
    input  logic [arstf_pkg::TEXEL_W-1:0] i_wdata,
    input  logic                          i_re,
    input  logic [arstf_pkg::MAP_AW-1:0]  i_raddr,
    output logic [arstf_pkg::TEXEL_W-1:0] o_rdata
);

    logic [arstf_pkg::TEXEL_W-1:0] r_mem [2**arstf_pkg::MAP_AW];
    logic [arstf_pkg::TEXEL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/arstf_setup.sv */
// ----------------------------------------------------------------------------
// arstf_setup
// Frame setup: configuration registers, trig lookup, step and origin.
// ----------------------------------------------------------------------------
module arstf_setup #(
    parameter int SCREEN_WIDTH  = arstf_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = arstf_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [arstf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [arstf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                             i_start,
    output logic                             o_busy,
    output arstf_pkg::t_setup                o_res
);

    localparam int PW = arstf_pkg::POS_W;
    localparam int TW = arstf_pkg::TRIG_W;
    localparam int ZW = arstf_pkg::ZOOM_W;
    localparam int MW = TW + ZW + 1;
    localparam logic [PW-1:0] HALF_W = PW'(SCREEN_WIDTH / 2);
    localparam logic [PW-1:0] HALF_H = PW'(SCREEN_HEIGHT / 2);

    typedef enum logic [2:0] {S_IDLE, S_ROM, S_MUL, S_PROD, S_SUM} t_state;

    t_state                r_state;
    logic [7:0]            r_angle;
    logic [ZW-1:0]         r_zoom;
    logic [7:0]            r_cx;
    logic [7:0]            r_cy;
    logic signed [TW-1:0]  r_cos;
    logic signed [TW-1:0]  r_sin;
    logic [PW-1:0]         r_sx_hw;
    logic [PW-1:0]         r_sy_hh;
    logic [PW-1:0]         r_sy_hw;
    logic [PW-1:0]         r_sx_hh;
    logic                  r_done;
    logic [PW-1:0]         r_step_x;
    logic [PW-1:0]         r_step_y;
    logic [PW-1:0]         r_org_x;
    logic [PW-1:0]         r_org_y;

    logic [7:0]            w_neg_angle;
    logic signed [ZW:0]    w_zoom;
    logic signed [MW-1:0]  w_prod_c;
    logic signed [MW-1:0]  w_prod_s;

    assign w_neg_angle = 8'(8'd0 - r_angle);
    assign w_zoom      = (r_zoom == '0) ? (ZW+1)'(1) : $signed({1'b0, r_zoom});
    assign w_prod_c    = r_cos * w_zoom;
    assign w_prod_s    = r_sin * w_zoom;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= 8'd0;
            r_zoom  <= ZW'(256);
            r_cx    <= 8'd128;
            r_cy    <= 8'd120;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                arstf_pkg::CFG_ANGLE:    r_angle <= i_cfg_data[7:0];
                arstf_pkg::CFG_ZOOM:     r_zoom  <= i_cfg_data[ZW-1:0];
                arstf_pkg::CFG_CENTER_X: r_cx    <= i_cfg_data[7:0];
                arstf_pkg::CFG_CENTER_Y: r_cy    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_ROM;
                    end
                end
                S_ROM: begin
                    r_sin   <= arstf_pkg::sine_of(w_neg_angle);
                    r_cos   <= arstf_pkg::sine_of(8'(w_neg_angle + 8'd64));
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_step_x <= {{(PW-(MW-8)){w_prod_c[MW-1]}}, w_prod_c[MW-1:8]};
                    r_step_y <= {{(PW-(MW-8)){w_prod_s[MW-1]}}, w_prod_s[MW-1:8]};
                    r_state  <= S_PROD;
                end
                S_PROD: begin
                    r_sx_hw <= PW'(r_step_x * HALF_W);
                    r_sy_hh <= PW'(r_step_y * HALF_H);
                    r_sy_hw <= PW'(r_step_y * HALF_W);
                    r_sx_hh <= PW'(r_step_x * HALF_H);
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_org_x <= PW'({r_cx, 8'd0} - r_sx_hw + r_sy_hh);
                    r_org_y <= PW'({r_cy, 8'd0} - r_sy_hw - r_sx_hh);
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy       = (r_state != S_IDLE) || r_done;
    assign o_res.done   = r_done;
    assign o_res.step_x = r_step_x;
    assign o_res.step_y = r_step_y;
    assign o_res.org_x  = r_org_x;
    assign o_res.org_y  = r_org_y;

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for affine_rotate_scale_texel_fetch.
// Map texels are loaded just before each render would first fetch them. A
// cycle-free model of the rotate/zoom raster predicts every pixel beat, and
// each beat on the output stream is checked field by field. A short directed
// opening is followed by randomized frames under several register settings
// with random gaps and output stalls. The run ends with a long stretch of one
// frame at full rate that crosses a row boundary.
// ----------------------------------------------------------------------------
module tb;

    localparam int FRAME_W        = arstf_pkg::SCREEN_WIDTH_DEF;
    localparam int FRAME_H        = arstf_pkg::SCREEN_HEIGHT_DEF;
    localparam int FINAL_PIXELS   = 300;
    localparam int RANDOM_ITEMS   = 880;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 12;
    localparam int MAX_REPORTS    = 40;

    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [15:0] pixel;
        logic [7:0]  col;
        logic [7:0]  row;
        logic        last;
    } t_pixel_beat;

    class raster_predictor;
        logic [15:0]       map_mem [65536];
        bit                map_valid [65536];
        logic signed [9:0] cos_tab [256];
        logic signed [9:0] sin_tab [256];
        logic [7:0]        angle;
        logic [10:0]       zoom;
        logic [7:0]        ctr_x;
        logic [7:0]        ctr_y;
        logic [31:0]       acc;
        logic [15:0]       org_x;
        logic [15:0]       org_y;
        logic [15:0]       step_x;
        logic [15:0]       step_y;
        int                col;
        int                row;
        bit                active;
        t_pixel_beat       expected_pixels [$];
        int                fails;

        function void reset_state();
            real v;
            for (int i = 0; i < 256; i++) begin
                v = 256.0 * $sin(6.283185307179586 * i / 256.0);
                sin_tab[i] = 10'($rtoi(v + ((v < 0.0) ? -1.0e-9 : 1.0e-9)));
            end
            for (int i = 0; i < 256; i++) begin
                cos_tab[i] = sin_tab[(i + 64) % 256];
            end
            foreach (map_valid[i]) map_valid[i] = 1'b0;
            angle  = 8'd0;
            zoom   = 11'd256;
            ctr_x  = 8'd128;
            ctr_y  = 8'd120;
            acc    = '0;
            org_x  = '0;
            org_y  = '0;
            step_x = '0;
            step_y = '0;
            col    = 0;
            row    = 0;
            active = 1'b0;
            fails  = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [10:0] val);
            case (idx)
                arstf_pkg::CFG_ANGLE:    angle = val[7:0];
                arstf_pkg::CFG_ZOOM:     zoom  = val;
                arstf_pkg::CFG_CENTER_X: ctr_x = val[7:0];
                arstf_pkg::CFG_CENTER_Y: ctr_y = val[7:0];
                default: ;
            endcase
        endfunction

        // floor(trig * zoom / 256), kept to 16 bits
        function logic [15:0] scaled_step(logic signed [9:0] trig, int z);
            int p;
            p = int'(trig) * z;
            return 16'(p >>> 8);
        endfunction

        function void start_frame();
            logic [7:0] a;
            int         z;
            int         sx;
            int         sy;
            int         ox;
            int         oy;
            a      = ~angle + 8'd1;
            z      = (zoom == 11'd0) ? 1 : int'(zoom);
            step_x = scaled_step(cos_tab[a], z);
            step_y = scaled_step(sin_tab[a], z);
            sx     = int'($signed(step_x));
            sy     = int'($signed(step_y));
            ox     = (int'(ctr_x) << 8) - sx * (FRAME_W / 2) + sy * (FRAME_H / 2);
            oy     = (int'(ctr_y) << 8) - sy * (FRAME_W / 2) - sx * (FRAME_H / 2);
            org_x  = 16'(ox);
            org_y  = 16'(oy);
            acc    = {org_y, org_x};
            col    = 0;
            row    = 0;
            active = 1'b1;
        endfunction

        function logic [15:0] fetch_addr();
            return {acc[31:24], acc[15:8]};
        endfunction

        function void accept_request(logic [1:0] req, logic [15:0] idx, logic [15:0] tex);
            t_pixel_beat beat;
            bit          last_col;
            bit          last_row;
            case (req)
                arstf_pkg::REQ_LOAD: begin
                    map_mem[idx]   = tex;
                    map_valid[idx] = 1'b1;
                end
                arstf_pkg::REQ_START: start_frame();
                arstf_pkg::REQ_RENDER: begin
                    if (active) begin
                        last_col   = (col + 1 >= FRAME_W);
                        last_row   = (row + 1 >= FRAME_H);
                        beat.pixel = map_mem[fetch_addr()];
                        beat.col   = 8'(col);
                        beat.row   = 8'(row);
                        beat.last  = last_col && last_row;
                        expected_pixels.push_back(beat);
                        if (!last_col) begin
                            acc = acc + {step_y, step_x};
                            col++;
                        end else begin
                            // next row starts perpendicular to the pixel step
                            org_x = org_x - step_y;
                            org_y = org_y + step_x;
                            acc   = {org_y, org_x};
                            col   = 0;
                            if (last_row) begin
                                active = 1'b0;
                            end else begin
                                row++;
                            end
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void report(string field, logic [15:0] want, logic [15:0] got);
            fails++;
            if (fails <= MAX_REPORTS) begin
                $error("%s mismatch: expected %h, got %h", field, want, got);
            end
        endfunction

        function void check_pixel(logic [31:0] data, logic last);
            t_pixel_beat want;
            if (expected_pixels.size() == 0) begin
                fails++;
                if (fails <= MAX_REPORTS) begin
                    $error("unexpected pixel beat: data %h, last %b", data, last);
                end
                return;
            end
            want = expected_pixels.pop_front();
            if (data[15:0] !== want.pixel) report("pixel", want.pixel, data[15:0]);
            if (data[23:16] !== want.col) report("screen_x", 16'(want.col), 16'(data[23:16]));
            if (data[31:24] !== want.row) report("screen_y", 16'(want.row), 16'(data[31:24]));
            if (last !== want.last) report("last_of_frame", 16'(want.last), 16'(last));
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [1:0]  i_cfg_idx     = '0;
    logic [10:0] i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // map_index, texel
    logic [1:0]  s_axis_tuser  = '0;   // req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [31:0] m_axis_tdata;         // pixel, screen_x, screen_y
    logic        m_axis_tlast;

    raster_predictor raster;
    bit              pacing_on  = 1'b0;
    int              items_sent = 0;
    int              rx_gap     = 0;

    affine_rotate_scale_texel_fetch i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            raster.check_pixel(m_axis_tdata, m_axis_tlast);
        end
        if (rx_gap > 0) begin
            rx_gap = rx_gap - 1;
        end else if (pacing_on && $urandom_range(0, 7) == 0) begin
            rx_gap = $urandom_range(1, 5);
        end
        m_axis_tready <= (rx_gap == 0);
    end

    task automatic send_beat(logic [1:0] req, logic [15:0] idx, logic [15:0] tex);
        if (pacing_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {tex, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        raster.accept_request(req, idx, tex);
        items_sent++;
    endtask

    // load the texel the next pixel fetches if it has not been written yet
    task automatic render_pixel();
        logic [15:0] addr;
        addr = raster.fetch_addr();
        if (raster.active && !raster.map_valid[addr]) begin
            send_beat(arstf_pkg::REQ_LOAD, addr, 16'($urandom));
        end
        send_beat(arstf_pkg::REQ_RENDER, 16'($urandom), 16'($urandom));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (raster.expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [10:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        raster.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    task automatic configure(bit every, logic [7:0] ang, logic [10:0] zm,
                             logic [7:0] cx, logic [7:0] cy);
        drain();
        if (every || $urandom_range(0, 3) != 0) write_reg(arstf_pkg::CFG_ANGLE, 11'(ang));
        if (every || $urandom_range(0, 3) != 0) write_reg(arstf_pkg::CFG_ZOOM, zm);
        if (every || $urandom_range(0, 3) != 0) write_reg(arstf_pkg::CFG_CENTER_X, 11'(cx));
        if (every || $urandom_range(0, 3) != 0) write_reg(arstf_pkg::CFG_CENTER_Y, 11'(cy));
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_frame(int pixels);
        int pick;
        send_beat(arstf_pkg::REQ_START, 16'($urandom), 16'($urandom));
        for (int n = 0; n < pixels; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 84) begin
                render_pixel();
            end else if (pick < 92) begin
                send_beat(arstf_pkg::REQ_LOAD, 16'($urandom), 16'($urandom));
            end else if (pick < 96) begin
                send_beat(REQ_UNUSED, 16'($urandom), 16'($urandom));
            end else begin
                send_beat(arstf_pkg::REQ_START, 16'($urandom), 16'($urandom));
            end
        end
    endtask

    initial begin
        int          stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("affine_rotate_scale_texel_fetch test failed");
        $finish;
    end

    initial begin
        logic [10:0] zm;
        int          phase;
        int          pixels;
        raster = new();
        raster.reset_state();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        pacing_on = 1'b1;
        send_beat(arstf_pkg::REQ_RENDER, 16'hffff, 16'hffff);
        send_beat(REQ_UNUSED, 16'hffff, 16'hffff);
        send_beat(arstf_pkg::REQ_LOAD, 16'h0000, 16'h0000);
        send_beat(arstf_pkg::REQ_LOAD, 16'hffff, 16'hffff);
        send_beat(arstf_pkg::REQ_START, 16'h0000, 16'h0000);
        repeat (4) render_pixel();
        // restart mid-frame
        send_beat(arstf_pkg::REQ_START, 16'hffff, 16'hffff);
        repeat (3) render_pixel();

        phase = 0;
        while (items_sent < RANDOM_ITEMS) begin
            pacing_on = ($urandom_range(0, 3) != 0);
            zm = 11'($urandom_range(0, 1280));
            if ($urandom_range(0, 7) == 0) begin
                zm = $urandom_range(0, 1) ? 11'd1280 : 11'd0;
            end
            case (phase)
                0: configure(1'b1, 8'd255, 11'd1280, 8'd0, 8'd0);
                1: configure(1'b1, 8'd0, 11'd0, 8'd255, 8'd255);
                default: configure(1'b0, 8'($urandom), zm, 8'($urandom), 8'($urandom));
            endcase
            pixels = ($urandom_range(0, 3) == 0) ? $urandom_range(260, 600)
                                                 : $urandom_range(1, 80);
            run_frame(pixels);
            phase++;
        end

        // a long stretch of one frame at full rate, across a row boundary
        pacing_on = 1'b0;
        configure(1'b1, 8'($urandom), 11'd1, 8'($urandom), 8'($urandom));
        send_beat(arstf_pkg::REQ_START, 16'($urandom), 16'($urandom));
        repeat (FINAL_PIXELS) render_pixel();
        drain();

        if (raster.fails == 0) begin
            $display("affine_rotate_scale_texel_fetch test passed");
        end else begin
            $display("affine_rotate_scale_texel_fetch test failed");
        end
        $finish;
    end

endmodule
